@@ rtl/core/cdsm_pkg.sv @@
`default_nettype none

package cdsm_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned MaxChannels = 64;
  localparam int unsigned MaxWidth    = 32;
  localparam int unsigned MinWidth    = 2;
  localparam int unsigned PosW        = $clog2(MaxChannels);
  localparam int unsigned WidthRegW   = 6;
  localparam int unsigned CountRegW   = 7;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 7;

  localparam logic [WidthRegW-1:0] WidthReset = WidthRegW'(8);
  localparam logic [CountRegW-1:0] CountReset = CountRegW'(1);

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgWordWidth    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgChannelCount = CfgIdxW'(1);

  // clamp the width register into its legal range
  function automatic logic [WidthRegW-1:0] eff_width(input logic [WidthRegW-1:0] w);
    logic [WidthRegW-1:0] r;
    r = w;
    if (w < WidthRegW'(MinWidth)) r = WidthRegW'(MinWidth);
    if (w > WidthRegW'(MaxWidth)) r = WidthRegW'(MaxWidth);
    return r;
  endfunction

  // clamp the channel count into 1..MaxChannels
  function automatic logic [CountRegW-1:0] eff_channels(input logic [CountRegW-1:0] c);
    logic [CountRegW-1:0] r;
    r = c;
    if (c == '0) r = CountRegW'(1);
    if (c > CountRegW'(MaxChannels)) r = CountRegW'(MaxChannels);
    return r;
  endfunction

  // low w bits set; w is already clamped to MinWidth..MaxWidth
  function automatic logic [DataW-1:0] width_mask(input logic [WidthRegW-1:0] w);
    return {DataW{1'b1}} >> (WidthRegW'(DataW) - w);
  endfunction

  // two's complement to sign-magnitude within w bits
  function automatic logic [DataW-1:0] sign_mag(input logic [DataW-1:0] v,
                                                input logic [WidthRegW-1:0] w);
    logic [DataW-1:0] mask;
    logic [DataW-1:0] sbit;
    logic [DataW-1:0] val;
    mask = width_mask(w);
    sbit = DataW'(1) << (w - WidthRegW'(1));
    val  = v & mask;
    if ((val & sbit) != '0) begin
      val = (((~val) & mask) + DataW'(1)) & mask;
      val = val | sbit;
    end
    return val;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/channel_delta_sign_magnitude_encoder.sv @@
`default_nettype none
// Channel   Direction  Handshake                   Payload
// in        sink       in_valid_i / in_ready_o     data_word_i[31:0]
// out       source     out_valid_o / out_ready_i   coded_word_o[31:0]
// cfg       sink       cfg_valid_i / cfg_ready_o   cfg_index_i[1:0], cfg_data_i[6:0]
//
// One word per cycle sustained while out_ready_i stays high; an accepted word is
// registered in the middle stage, then in the output register behind out_valid_o.
// The delay line is a 64 x 32 memory, read and written at the same address
// in the accept cycle; the difference and recoding sit in the next stage.
// Reset clears the fill count and write position; the delay line is not cleared.
// A stalled output holds its word; the middle stage keeps accepting until both
// stages are full.
module channel_delta_sign_magnitude_encoder
  import cdsm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [DataW-1:0]     data_word_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [DataW-1:0]          coded_word_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i
);

  logic [DataW-1:0]     delay_mem [MaxChannels];

  logic [WidthRegW-1:0] width_q;
  logic [CountRegW-1:0] count_q;
  logic [PosW-1:0]      pos_q, pos_d;
  logic [CountRegW-1:0] fill_q, fill_d;

  logic                 s1_valid_q;
  logic [DataW-1:0]     word_q;
  logic [DataW-1:0]     rd_q;
  logic                 raw_q;

  logic                 out_valid_q;
  logic [DataW-1:0]     coded_q;
  logic [DataW-1:0]     coded_d;
  logic [DataW-1:0]     diff;

  logic [WidthRegW-1:0] eff_w;
  logic [CountRegW-1:0] eff_ch;
  logic [CountRegW-1:0] pos_inc;
  logic                 in_acc;
  logic                 s1_adv;
  logic                 cfg_hit;
  logic                 fill_open;

  assign eff_w  = eff_width(width_q);
  assign eff_ch = eff_channels(count_q);

  assign s1_adv     = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | s1_adv;
  assign in_acc     = in_valid_i & in_ready_o;

  assign cfg_ready_o = 1'b1;
  assign cfg_hit     = cfg_valid_i & ((cfg_index_i == CfgWordWidth) ||
                                      (cfg_index_i == CfgChannelCount));

  assign fill_open = fill_q < eff_ch;

  always_comb begin
    pos_inc = CountRegW'(pos_q) + CountRegW'(1);
    pos_d   = pos_q;
    fill_d  = fill_q;
    if (cfg_hit) begin
      pos_d  = '0;
      fill_d = '0;
    end else if (in_acc) begin
      // wrap the circular position at the channel count
      pos_d = (pos_inc >= eff_ch) ? '0 : pos_inc[PosW-1:0];
      if (fill_open) fill_d = fill_q + CountRegW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthReset;
      count_q <= CountReset;
      pos_q   <= '0;
      fill_q  <= '0;
    end else begin
      if (cfg_valid_i && (cfg_index_i == CfgWordWidth)) begin
        width_q <= cfg_data_i[WidthRegW-1:0];
      end
      if (cfg_valid_i && (cfg_index_i == CfgChannelCount)) begin
        count_q <= cfg_data_i[CountRegW-1:0];
      end
      pos_q  <= pos_d;
      fill_q <= fill_d;
    end
  end

  // read the old word and store the new one at the same slot
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q             <= delay_mem[pos_q];
      delay_mem[pos_q] <= data_word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      word_q <= data_word_i;
      raw_q  <= fill_open;
    end
  end

  assign diff    = raw_q ? word_q : (word_q - rd_q);
  assign coded_d = sign_mag(diff, eff_w);

  always_ff @(posedge clk_i) begin
    if (s1_adv) coded_q <= coded_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign coded_word_o = coded_q;

endmodule

`default_nettype wire

@@ rtl/core/cdsm_checker.sv @@
`default_nettype none

module cdsm_checker
  import cdsm_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire logic [DataW-1:0]     data_word_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire logic [DataW-1:0]     coded_word_o,
  input wire logic                 cfg_valid_i,
  input wire logic                 cfg_ready_o,
  input wire logic [CfgIdxW-1:0]   cfg_index_i,
  input wire logic [CfgDataW-1:0]  cfg_data_i
);

  logic [1:0]           occ_q;
  logic [WidthRegW-1:0] width_q;
  logic                 in_acc;
  logic                 out_acc;

  assign in_acc  = in_valid_i & in_ready_o;
  assign out_acc = out_valid_o & out_ready_i;

  // track words in flight and the current width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= '0;
      width_q <= WidthReset;
    end else begin
      occ_q <= occ_q + 2'(in_acc) - 2'(out_acc);
      if (cfg_valid_i && cfg_ready_o && (cfg_index_i == CfgWordWidth)) begin
        width_q <= cfg_data_i[WidthRegW-1:0];
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(coded_word_o))
    else $error("output word changed while stalled");

  a_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((coded_word_o & ~width_mask(eff_width(width_q))) == '0))
    else $error("bits above word width set");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (occ_q != 2'd0))
    else $error("output word without accepted input");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q != 2'd3) && ((occ_q != 2'd2) || !in_acc || out_acc))
    else $error("more than two words in flight");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind channel_delta_sign_magnitude_encoder cdsm_checker u_cdsm_checker (.*);

`default_nettype wire
